>>> rtl/rabst_pkg.sv
// Shared types, widths and register codes for the ray/box slab test.
`timescale 1ns / 1ps

package rabst_pkg;

    localparam int DATA_W        = 32;
    localparam int LEN_W         = 31;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int STAGES        = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    // Near/far slab distances of one axis
    typedef struct packed {
        logic signed [DATA_W-1:0] tn;
        logic signed [DATA_W-1:0] tf;
    } slab_t;

    // Per-stage load enables of the slab lanes
    typedef struct packed {
        logic diff;
        logic prod;
        logic sat;
    } lane_en_t;

endpackage

>>> rtl/rabst_slab_lane.sv
// One axis of the slab test: difference, multiply, then shift and saturate.
`timescale 1ns / 1ps

module rabst_slab_lane #(
    parameter int FRAC_BITS = rabst_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  rabst_pkg::lane_en_t                    en,
    input  logic signed [rabst_pkg::DATA_W-1:0]    bound_lo,
    input  logic signed [rabst_pkg::DATA_W-1:0]    bound_hi,
    input  logic signed [rabst_pkg::DATA_W-1:0]    origin,
    input  logic signed [rabst_pkg::DATA_W-1:0]    inv_dir,
    input  logic                                   dir_neg,
    output rabst_pkg::slab_t                       slab
);

    localparam int DW = rabst_pkg::DATA_W;
    localparam int PW = 2 * DW + 1;

    logic signed [DW:0]   dn_reg, dn_next, df_reg, df_next;
    logic signed [DW-1:0] inv_reg;
    logic signed [PW-1:0] pn_reg, pn_next, pf_reg, pf_next;
    rabst_pkg::slab_t     slab_reg, slab_next;
    logic signed [DW-1:0] near_b, far_b;
    logic signed [PW-1:0] sh_n, sh_f;

    function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
        logic [PW-DW:0] top;
        logic signed [DW-1:0] r;
        top = v[PW-1:DW-1];
        if (&top || ~|top)
            r = v[DW-1:0];
        else if (v[PW-1])
            r = {1'b1, {(DW-1){1'b0}}};
        else
            r = {1'b0, {(DW-1){1'b1}}};
        return r;
    endfunction

    // Stage 1: pick near/far bounds and form exact differences
    always_comb
    begin
        near_b  = dir_neg ? bound_hi : bound_lo;
        far_b   = dir_neg ? bound_lo : bound_hi;
        dn_next = {near_b[DW-1], near_b} - {origin[DW-1], origin};
        df_next = {far_b[DW-1], far_b} - {origin[DW-1], origin};
    end

    // Stage 2: exact products
    always_comb
    begin
        pn_next = dn_reg * inv_reg;
        pf_next = df_reg * inv_reg;
    end

    // Stage 3: floor shift, then saturate to 32 bits
    always_comb
    begin
        sh_n         = pn_reg >>> FRAC_BITS;
        sh_f         = pf_reg >>> FRAC_BITS;
        slab_next.tn = sat32(sh_n);
        slab_next.tf = sat32(sh_f);
    end

    always_ff @(posedge clk)
    begin
        if (en.diff)
        begin
            dn_reg  <= dn_next;
            df_reg  <= df_next;
            inv_reg <= inv_dir;
        end
        if (en.prod)
        begin
            pn_reg <= pn_next;
            pf_reg <= pf_next;
        end
        if (en.sat)
            slab_reg <= slab_next;
    end

    assign slab = slab_reg;

endmodule

>>> rtl/rabst_merge.sv
// Interval narrowing over x/y then z, with early rejection and the hit decision.
`timescale 1ns / 1ps

module rabst_merge (
    input  logic                                 clk,
    input  logic                                 en_xy,
    input  logic                                 en_z,
    input  rabst_pkg::slab_t                     sx,
    input  rabst_pkg::slab_t                     sy,
    input  rabst_pkg::slab_t                     sz,
    input  logic [rabst_pkg::LEN_W-1:0]          len,
    output logic                                 hit,
    output logic signed [rabst_pkg::DATA_W-1:0]  t_enter,
    output logic signed [rabst_pkg::DATA_W-1:0]  t_exit
);

    localparam int DW = rabst_pkg::DATA_W;

    logic signed [DW-1:0]            tmin_reg, tmin_next, tmax_reg, tmax_next;
    logic                            rej_reg, rej_next;
    rabst_pkg::slab_t                sz_reg;
    logic [rabst_pkg::LEN_W-1:0]     len_reg;
    logic                            hit_reg, hit_next;
    logic signed [DW-1:0]            ten_reg, ten_next, tex_reg, tex_next;
    logic signed [DW-1:0]            len_s;

    // Stage 4: merge x with y
    always_comb
    begin
        rej_next  = (sx.tn > sy.tf) || (sy.tn > sx.tf);
        tmin_next = sx.tn;
        tmax_next = sx.tf;
        if (!rej_next)
        begin
            if (sy.tn > sx.tn)
                tmin_next = sy.tn;
            if (sy.tf < sx.tf)
                tmax_next = sy.tf;
        end
    end

    // Stage 5: merge z and decide
    always_comb
    begin
        len_s    = {1'b0, len_reg};
        ten_next = tmin_reg;
        tex_next = tmax_reg;
        hit_next = 1'b0;
        if (!rej_reg && !((tmin_reg > sz_reg.tf) || (sz_reg.tn > tmax_reg)))
        begin
            if (sz_reg.tn > tmin_reg)
                ten_next = sz_reg.tn;
            if (sz_reg.tf < tmax_reg)
                tex_next = sz_reg.tf;
            hit_next = (ten_next < len_s) && (tex_next > 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_xy)
        begin
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
            rej_reg  <= rej_next;
            sz_reg   <= sz;
            len_reg  <= len;
        end
        if (en_z)
        begin
            hit_reg <= hit_next;
            ten_reg <= ten_next;
            tex_reg <= tex_next;
        end
    end

    assign hit     = hit_reg;
    assign t_enter = ten_reg;
    assign t_exit  = tex_reg;

endmodule

>>> rtl/ray_aabb_slab_test_top.sv
// Top level of the ray against axis-aligned box slab test pipeline.
`timescale 1ns / 1ps

// Tests one ray per clock, unless in_stall holds the input, against the box held
// in the six bound registers (signed fixed point with FRAC_BITS fraction bits,
// all zero after reset). A ray word passes five register stages: bound minus
// origin, the 33x32 slab multiply, floor shift with saturation, x/y interval
// merge, then z merge and the hit decision. A new word can be taken every
// cycle while in_stall is low; the figure is set by the single multiply stage
// per lane. Each stage holds its word only while the stage ahead is full and
// cannot move, so bubbles close up behind a stalled result and in_stall rises
// only once the whole pipe is full. Write the bound registers only while the
// pipe is empty; writes to an index above five are dropped.

module ray_aabb_slab_test_top #(
    parameter int FRAC_BITS = rabst_pkg::FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration
    input  logic                                      cfg_we,
    input  logic [rabst_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [rabst_pkg::DATA_W-1:0]              cfg_data,
    // ray input channel
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [rabst_pkg::DATA_W-1:0]       origin_x,
    input  logic signed [rabst_pkg::DATA_W-1:0]       origin_y,
    input  logic signed [rabst_pkg::DATA_W-1:0]       origin_z,
    input  logic signed [rabst_pkg::DATA_W-1:0]       inv_dir_x,
    input  logic signed [rabst_pkg::DATA_W-1:0]       inv_dir_y,
    input  logic signed [rabst_pkg::DATA_W-1:0]       inv_dir_z,
    input  logic                                      dir_neg_x,
    input  logic                                      dir_neg_y,
    input  logic                                      dir_neg_z,
    input  logic [rabst_pkg::LEN_W-1:0]               ray_length,
    // result channel
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic                                      hit,
    output logic signed [rabst_pkg::DATA_W-1:0]       t_enter,
    output logic signed [rabst_pkg::DATA_W-1:0]       t_exit
);

    localparam int DW = rabst_pkg::DATA_W;
    localparam int NS = rabst_pkg::STAGES;

    // Box bound registers
    logic signed [DW-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [DW-1:0] max_x_reg, max_y_reg, max_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
            max_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rabst_pkg::REG_BOX_MIN_X: min_x_reg <= cfg_data;
                rabst_pkg::REG_BOX_MIN_Y: min_y_reg <= cfg_data;
                rabst_pkg::REG_BOX_MIN_Z: min_z_reg <= cfg_data;
                rabst_pkg::REG_BOX_MAX_X: max_x_reg <= cfg_data;
                rabst_pkg::REG_BOX_MAX_Y: max_y_reg <= cfg_data;
                rabst_pkg::REG_BOX_MAX_Z: max_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage advance; a stage loads when it is
    // empty or the stage ahead moves on.
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
            vld_next[0] = in_valid;
        for (int k = 1; k < NS; k++)
            if (adv[k])
                vld_next[k] = vld_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NS-1];

    // Carry the ray length alongside the three lane stages
    logic [rabst_pkg::LEN_W-1:0] len_s1_reg, len_s2_reg, len_s3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
            len_s1_reg <= ray_length;
        if (adv[1])
            len_s2_reg <= len_s1_reg;
        if (adv[2])
            len_s3_reg <= len_s2_reg;
    end

    rabst_pkg::lane_en_t lane_en;
    rabst_pkg::slab_t    sx, sy, sz;

    assign lane_en.diff = adv[0];
    assign lane_en.prod = adv[1];
    assign lane_en.sat  = adv[2];

    rabst_slab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk      (clk),
        .en       (lane_en),
        .bound_lo (min_x_reg),
        .bound_hi (max_x_reg),
        .origin   (origin_x),
        .inv_dir  (inv_dir_x),
        .dir_neg  (dir_neg_x),
        .slab     (sx)
    );

    rabst_slab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk      (clk),
        .en       (lane_en),
        .bound_lo (min_y_reg),
        .bound_hi (max_y_reg),
        .origin   (origin_y),
        .inv_dir  (inv_dir_y),
        .dir_neg  (dir_neg_y),
        .slab     (sy)
    );

    rabst_slab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk      (clk),
        .en       (lane_en),
        .bound_lo (min_z_reg),
        .bound_hi (max_z_reg),
        .origin   (origin_z),
        .inv_dir  (inv_dir_z),
        .dir_neg  (dir_neg_z),
        .slab     (sz)
    );

    rabst_merge u_merge (
        .clk     (clk),
        .en_xy   (adv[3]),
        .en_z    (adv[4]),
        .sx      (sx),
        .sy      (sy),
        .sz      (sz),
        .len     (len_s3_reg),
        .hit     (hit),
        .t_enter (t_enter),
        .t_exit  (t_exit)
    );

    // A full first stage is the only reason to hold off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> vld_reg[0])
        else $error("input stalled with an empty first stage");

    // A word taken with no word leaving adds exactly one to the occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !(out_valid && !out_stall))
        |=> $countones(vld_reg) == $past($countones(vld_reg)) + 1)
        else $error("pipeline occupancy lost or duplicated a word");

    // A hit always leaves the box in front of the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (t_exit > 0))
        else $error("hit reported with exit distance not positive");

endmodule
